@@ rtl/fcsg_pkg.sv @@
// Shared types and constants for the filled circle span generator.
// Used by fcsg_front, fcsg_back and the top level; depends on nothing.
package fcsg_pkg;

    localparam int CoordW  = 12;  // center coordinate width
    localparam int RadW    = 5;   // radius width
    localparam int ColorW  = 24;  // color width
    localparam int SpanW   = 14;  // signed span coordinate width
    localparam int OffW    = 6;   // column and row offset width
    localparam int ErrW    = 8;   // midpoint error term width
    localparam int QDepth  = 2;   // request queue depth
    localparam int QPtrW   = 1;   // queue pointer width
    localparam int QCntW   = 2;   // queue fill count width

    // One classified circle request
    typedef struct packed {
        logic [CoordW-1:0] cx;
        logic [CoordW-1:0] cy;
        logic [RadW-1:0]   rad;
        logic [ColorW-1:0] color;
    } t_req;

endpackage

@@ rtl/fcsg_front.sv @@
// Request front end: masks the center, saturates the radius and queues requests.
// Depends on fcsg_pkg.
module fcsg_front
    import fcsg_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int RADIUS_MAX = 31
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CoordW-1:0] i_center_x,
    input  logic [CoordW-1:0] i_center_y,
    input  logic [RadW-1:0]   i_circle_radius,
    input  logic [ColorW-1:0] i_fill_color,
    output logic              o_q_valid,
    output t_req              o_q_req,
    input  logic              i_q_pop
);

    // Keep only the low COORD_BITS bits of a center coordinate
    localparam logic [CoordW-1:0] CMask = (COORD_BITS >= CoordW) ? {CoordW{1'b1}} :
                                          CoordW'((64'd1 << COORD_BITS) - 64'd1);
    localparam logic [RadW-1:0] RadMax = RadW'(RADIUS_MAX);

    t_req               s_req;
    logic               s_push;
    t_req               r_mem [QDepth];
    logic [QPtrW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPtrW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCntW-1:0]   r_count, n_count;

    // Classify the incoming request
    always_comb begin
        s_req.cx    = i_center_x & CMask;
        s_req.cy    = i_center_y & CMask;
        s_req.rad   = (i_circle_radius > RadMax) ? RadMax : i_circle_radius;
        s_req.color = i_fill_color;
    end

    assign o_stall   = (r_count == QCntW'(QDepth));
    assign s_push    = i_valid && !o_stall;
    assign o_q_valid = (r_count != '0);
    assign o_q_req   = r_mem[r_rd_ptr];

    // Advance pointers and fill count
    always_comb begin
        n_wr_ptr = s_push  ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_q_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + QCntW'(s_push) - QCntW'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the request payload
    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_mem[r_wr_ptr] <= s_req;
        end
    end

endmodule

@@ rtl/fcsg_back.sv @@
// Span sequencer: steps the midpoint circle error term, one span per cycle while i_stall is low.
// Depends on fcsg_pkg; pulls requests from the fcsg_front queue.
module fcsg_back
    import fcsg_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_valid,
    input  t_req                    i_q_req,
    output logic                    o_q_pop,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [SpanW-1:0] o_span_left,
    output logic signed [SpanW-1:0] o_span_right,
    output logic signed [SpanW-1:0] o_span_row,
    output logic [ColorW-1:0]       o_span_color,
    output logic                    o_last_span
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_POS  = 3'd1;
    localparam logic [2:0] PH_NEG  = 3'd2;
    localparam logic [2:0] PH_OCTP = 3'd3;
    localparam logic [2:0] PH_OCTN = 3'd4;

    logic [2:0]        r_phase, n_phase;
    logic [CoordW-1:0] r_cx, n_cx, r_cy, n_cy;
    logic [ColorW-1:0] r_color, n_color;
    logic [OffW-1:0]   r_xo, n_xo, r_yo, n_yo;
    logic [ErrW-1:0]   r_err, n_err;
    logic              r_pend, n_pend;

    logic              r_valid;
    logic [SpanW-1:0]  r_left, r_right, r_row;
    logic [ColorW-1:0] r_ocolor;
    logic              r_last;

    logic              s_adv, s_emit;
    logic [OffW-1:0]   s_half, s_off;
    logic              s_neg, s_last;
    logic [ErrW-1:0]   s_err1, s_err2;
    logic [OffW-1:0]   s_yo1;
    logic              s_shrink;

    assign s_adv   = !r_valid || !i_stall;
    assign o_q_pop = s_adv && (r_phase == PH_IDLE) && i_q_valid;
    assign s_emit  = o_q_pop || (s_adv && (r_phase != PH_IDLE));

    // One midpoint step: move the row offset, shrink the column offset on underflow
    always_comb begin
        s_err1   = r_err - (ErrW'(r_yo) << 1) - ErrW'(1);
        s_yo1    = r_yo + OffW'(1);
        s_shrink = s_err1[ErrW-1];
        s_err2   = s_shrink ? s_err1 + (ErrW'(r_xo) << 1) - ErrW'(1) : s_err1;
    end

    // Sequence the spans of one circle
    always_comb begin
        n_phase = r_phase;
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_color = r_color;
        n_xo    = r_xo;
        n_yo    = r_yo;
        n_err   = r_err;
        n_pend  = r_pend;
        s_half  = r_xo;
        s_off   = r_yo;
        s_neg   = 1'b0;
        s_last  = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                n_cx    = i_q_req.cx;
                n_cy    = i_q_req.cy;
                n_color = i_q_req.color;
                n_xo    = OffW'(i_q_req.rad);
                n_yo    = '0;
                n_err   = ErrW'(i_q_req.rad);
                n_pend  = 1'b0;
                s_half  = OffW'(i_q_req.rad);
                s_off   = '0;
                s_last  = (i_q_req.rad == '0);
                if (o_q_pop) begin
                    n_phase = s_last ? PH_IDLE : PH_POS;
                end else begin
                    n_cx    = r_cx;
                    n_cy    = r_cy;
                    n_color = r_color;
                    n_xo    = r_xo;
                    n_yo    = r_yo;
                    n_err   = r_err;
                    n_pend  = r_pend;
                end
            end
            PH_POS: begin
                s_half = s_shrink ? r_xo - OffW'(1) : r_xo;
                s_off  = s_yo1;
                if (s_adv) begin
                    n_xo    = s_half;
                    n_yo    = s_yo1;
                    n_err   = s_err2;
                    n_pend  = s_shrink;
                    n_phase = PH_NEG;
                end
            end
            PH_NEG: begin
                s_neg  = 1'b1;
                s_last = !r_pend && !(r_yo < r_xo);
                if (s_adv) begin
                    n_phase = r_pend ? PH_OCTP : ((r_yo < r_xo) ? PH_POS : PH_IDLE);
                end
            end
            PH_OCTP: begin
                s_half = r_yo;
                s_off  = r_xo;
                if (s_adv) begin
                    n_phase = PH_OCTN;
                end
            end
            PH_OCTN: begin
                s_half = r_yo;
                s_off  = r_xo;
                s_neg  = 1'b1;
                s_last = !(r_yo < r_xo);
                if (s_adv) begin
                    n_pend  = 1'b0;
                    n_phase = (r_yo < r_xo) ? PH_POS : PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_valid <= 1'b0;
            r_xo    <= '0;
            r_yo    <= '0;
            r_err   <= '0;
            r_pend  <= 1'b0;
            r_cx    <= '0;
            r_cy    <= '0;
            r_color <= '0;
        end else begin
            r_phase <= n_phase;
            r_valid <= s_emit || (r_valid && i_stall);
            r_xo    <= n_xo;
            r_yo    <= n_yo;
            r_err   <= n_err;
            r_pend  <= n_pend;
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            r_color <= n_color;
        end
    end

    // Load the output register with the selected span
    always_ff @(posedge i_clk) begin
        if (s_emit) begin
            r_left   <= SpanW'(n_cx) - SpanW'(s_half);
            r_right  <= SpanW'(n_cx) + SpanW'(s_half);
            r_row    <= s_neg ? SpanW'(n_cy) - SpanW'(s_off) : SpanW'(n_cy) + SpanW'(s_off);
            r_ocolor <= n_color;
            r_last   <= s_last;
        end
    end

    assign o_valid      = r_valid;
    assign o_span_left  = r_left;
    assign o_span_right = r_right;
    assign o_span_row   = r_row;
    assign o_span_color = r_ocolor;
    assign o_last_span  = r_last;

endmodule

@@ rtl/filled_circle_span_generator_core.sv @@
// Filled circle span generator, top level.
// Depends on fcsg_pkg, fcsg_front and fcsg_back.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one circle request: center,
//   radius and color. Output channel (o_valid / i_stall) carries one
//   horizontal span per item: left, right, row, color, last flag.
//   A request yields 1 + 2*n + 2*k spans (n = row steps, k = column
//   steps); radius 31 yields 63. The last span of each circle has o_last_span set.
//   An accepted request goes through the queue before its first span is registered.
//   Throughput: one span per cycle while i_stall is low, set by the single span
//   sequencer; the spans of a circle go out back to back with the next circle's.
//   A two-entry request queue lets new requests in while spans go out; the
//   input stalls only when the queue is full.
//   When i_stall is high the current span holds in the output register and
//   the sequencer pauses; the queue keeps filling.
//   Reset (i_rst_n low, synchronous) empties the queue, idles the sequencer
//   and drops any span in the output register.
module filled_circle_span_generator_core
    import fcsg_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int RADIUS_MAX = 31
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [CoordW-1:0]       i_center_x,
    input  logic [CoordW-1:0]       i_center_y,
    input  logic [RadW-1:0]         i_circle_radius,
    input  logic [ColorW-1:0]       i_fill_color,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [SpanW-1:0] o_span_left,
    output logic signed [SpanW-1:0] o_span_right,
    output logic signed [SpanW-1:0] o_span_row,
    output logic [ColorW-1:0]       o_span_color,
    output logic                    o_last_span
);

    logic q_valid;
    t_req q_req;
    logic q_pop;

    fcsg_front #(
        .COORD_BITS (COORD_BITS),
        .RADIUS_MAX (RADIUS_MAX)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_center_x      (i_center_x),
        .i_center_y      (i_center_y),
        .i_circle_radius (i_circle_radius),
        .i_fill_color    (i_fill_color),
        .o_q_valid       (q_valid),
        .o_q_req         (q_req),
        .i_q_pop         (q_pop)
    );

    fcsg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_req      (q_req),
        .o_q_pop      (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_span_left  (o_span_left),
        .o_span_right (o_span_right),
        .o_span_row   (o_span_row),
        .o_span_color (o_span_color),
        .o_last_span  (o_last_span)
    );

    // Never pop an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("request popped from empty queue");

    // A span is symmetric about its center column
    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_span_left <= o_span_right && o_span_left[0] == o_span_right[0]))
        else $error("span edges out of order or asymmetric");

    // A new request is taken only once the output can move
    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (!o_valid || !i_stall))
        else $error("request popped while output stalled");

endmodule
